### src/input_event_decoder_assert.svh
// Assertion macros for the input event decoder.
// Included by modules that check their own logic; no other dependencies.
// The macros assume a clock named clk and an active-low reset named rst_n.
`ifndef INPUT_EVENT_DECODER_ASSERT_SVH
`define INPUT_EVENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that an implication or expression holds at every clock edge out of reset.
`define IED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition never occurs at a clock edge out of reset.
`define IED_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define IED_ASSERT(lbl, prop, msg)
`define IED_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### src/ied_pkg.sv
// Package for the input event decoder: event and report codes, key and
// modifier decode helpers, and default sizes. No dependencies.

package ied_pkg;

    localparam int COORD_BITS_DEF = 32;

    // Event types.
    localparam logic [15:0] EV_SYN = 16'd0;
    localparam logic [15:0] EV_KEY = 16'd1;
    localparam logic [15:0] EV_REL = 16'd2;

    // Relative axes.
    localparam logic [15:0] AXIS_X = 16'd0;
    localparam logic [15:0] AXIS_Y = 16'd1;

    // Pointer button code range.
    localparam logic [15:0] BTN_FIRST = 16'h0110;
    localparam logic [15:0] BTN_LAST  = 16'h0114;

    // Modifier key codes, one pair per modifier.
    localparam logic [15:0] CODE_CTRL_L  = 16'd29;
    localparam logic [15:0] CODE_CTRL_R  = 16'd97;
    localparam logic [15:0] CODE_SHIFT_L = 16'd42;
    localparam logic [15:0] CODE_SHIFT_R = 16'd54;
    localparam logic [15:0] CODE_ALT_L   = 16'd56;
    localparam logic [15:0] CODE_ALT_R   = 16'd100;

    // Modifier bit masks.
    localparam logic [2:0] MOD_NONE  = 3'b000;
    localparam logic [2:0] MOD_CTRL  = 3'b001;
    localparam logic [2:0] MOD_SHIFT = 3'b010;
    localparam logic [2:0] MOD_ALT   = 3'b100;

    // Report kinds.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_MOVE   = 2'd2;

    // Key states.
    localparam logic [1:0] KS_RELEASED = 2'd0;
    localparam logic [1:0] KS_PRESSED  = 2'd1;
    localparam logic [1:0] KS_REPEAT   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACCEL   = 2'd0;
    localparam logic [1:0] CFG_START_X = 2'd1;
    localparam logic [1:0] CFG_START_Y = 2'd2;

    localparam logic [7:0] ACCEL_RESET = 8'd3;

    typedef logic [1:0] key_state_t;
    typedef logic [2:0] mod_mask_t;

    // Clamp a raw key value to released, pressed or repeat.
    function automatic key_state_t sat_state(input logic [31:0] raw);
        key_state_t st;
        if (raw[31])
            st = KS_RELEASED;
        else if (raw > 32'd2)
            st = KS_REPEAT;
        else
            st = raw[1:0];
        return st;
    endfunction

    // Modifier mask for a key code, or no bits if it is not a modifier.
    function automatic mod_mask_t mod_bit(input logic [15:0] code);
        mod_mask_t m;
        unique case (code)
            CODE_CTRL_L, CODE_CTRL_R:   m = MOD_CTRL;
            CODE_SHIFT_L, CODE_SHIFT_R: m = MOD_SHIFT;
            CODE_ALT_L, CODE_ALT_R:     m = MOD_ALT;
            default:                    m = MOD_NONE;
        endcase
        return m;
    endfunction

endpackage

### src/ied_event_if.sv
// Valid/ready channel that carries one input event record per transaction.
// Standalone; no package dependencies.

interface ied_event_if;
    logic        valid;
    logic        ready;
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;

    modport source (output valid, ev_type, ev_code, ev_value, input ready);
    modport sink   (input valid, ev_type, ev_code, ev_value, output ready);
endinterface

### src/ied_report_if.sv
// Valid/ready channel that carries one decoded report per transaction.
// Standalone; no package dependencies.

interface ied_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  report_kind;
    logic [1:0]  key_state;
    logic [2:0]  modifier_bits;
    logic [15:0] key_code;
    logic [2:0]  button_id;
    logic [31:0] pos_x;
    logic [31:0] pos_y;

    modport source (output valid, report_kind, key_state, modifier_bits, key_code,
                     button_id, pos_x, pos_y, input ready);
    modport sink   (input valid, report_kind, key_state, modifier_bits, key_code,
                     button_id, pos_x, pos_y, output ready);
endinterface

### src/input_event_decoder.sv
// Input event decoder: an accepted event is registered in stage one, and any
// report it makes is loaded into the report register; one event is accepted
// every cycle while the report register drains. The rate is set by the input
// register and the single report register, with the motion multiply in the first
// stage and the position add in the second. Reset clears the modifiers, position
// and moved flag, sets the acceleration to 3, and empties both stages at once.
// Depends on ied_pkg, ied_event_if, ied_report_if and the assertion header.

`include "input_event_decoder_assert.svh"

module input_event_decoder
    import ied_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    ied_event_if.sink           events,
    ied_report_if.source        reports,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int PROD_BITS = COORD_BITS + 8;

    // The pipeline has two stages. Stage one registers the event with its key
    // value already clamped and its motion delta already multiplied by the
    // acceleration. Stage two decodes the registered event against the
    // architectural state, updates that state and loads the report register.
    // Stage one advances whenever the report register is empty or is being
    // drained in the same cycle, so a stalled consumer holds both stages.

    // Stage one registers.
    logic                    s1_valid_reg;
    logic [15:0]             s1_type_reg;
    logic [15:0]             s1_code_reg;
    key_state_t              s1_state_reg;
    logic [COORD_BITS-1:0]   s1_delta_reg;

    // Architectural state.
    logic [7:0]              accel_reg;
    mod_mask_t               held_mods_reg;
    mod_mask_t               held_mods_next;
    logic [COORD_BITS-1:0]   cur_x_reg;
    logic [COORD_BITS-1:0]   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg;
    logic [COORD_BITS-1:0]   cur_y_next;
    logic                    moved_reg;
    logic                    moved_next;

    // Report register.
    logic                    out_valid_reg;
    logic [1:0]              kind_reg;
    logic [1:0]              kind_next;
    key_state_t              kstate_reg;
    key_state_t              kstate_next;
    mod_mask_t               mods_reg;
    logic [15:0]             kcode_reg;
    logic [15:0]             kcode_next;
    logic [2:0]              btn_reg;
    logic [2:0]              btn_next;
    logic [31:0]             px_reg;
    logic [31:0]             px_next;
    logic [31:0]             py_reg;
    logic [31:0]             py_next;
    logic                    emit;

    logic                    out_free;
    logic                    s1_adv;
    logic                    in_take;
    logic [PROD_BITS-1:0]    prod_full;
    logic                    is_btn;
    mod_mask_t               mod_hit;
    logic [15:0]             btn_off;

    // A new report can be loaded when the report register is empty or its
    // transaction completes in this cycle.
    assign out_free = !out_valid_reg || reports.ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_take  = events.valid && events.ready;

    assign events.ready = !s1_valid_reg || out_free;

    // The product is only needed modulo 2^COORD_BITS, so the low bits of the
    // value can be multiplied as unsigned.
    assign prod_full = PROD_BITS'(events.ev_value[COORD_BITS-1:0])
                       * PROD_BITS'(accel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            s1_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg  <= events.ev_type;
            s1_code_reg  <= events.ev_code;
            s1_state_reg <= sat_state(events.ev_value);
            s1_delta_reg <= prod_full[COORD_BITS-1:0];
        end
    end

    // Stage two decode.
    assign is_btn  = (s1_code_reg >= BTN_FIRST) && (s1_code_reg <= BTN_LAST);
    assign mod_hit = mod_bit(s1_code_reg);
    assign btn_off = s1_code_reg - BTN_FIRST;

    always_comb
    begin
        held_mods_next = held_mods_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        moved_next     = moved_reg;
        emit           = 1'b0;
        kind_next      = KIND_KEY;
        kstate_next    = KS_RELEASED;
        kcode_next     = 16'd0;
        btn_next       = 3'd0;
        px_next        = 32'd0;
        py_next        = 32'd0;

        priority if (s1_type_reg == EV_KEY)
        begin
            if (is_btn)
            begin
                // Button press or release: report with the current position.
                emit        = 1'b1;
                kind_next   = KIND_BUTTON;
                kstate_next = s1_state_reg;
                kcode_next  = s1_code_reg;
                btn_next    = btn_off[2:0];
                px_next     = 32'($signed(cur_x_reg));
                py_next     = 32'($signed(cur_y_reg));
                moved_next  = 1'b0;
            end
            else if (mod_hit != MOD_NONE)
            begin
                // Modifier keys only update the held mask.
                if (s1_state_reg == KS_PRESSED || s1_state_reg == KS_REPEAT)
                    held_mods_next = held_mods_reg | mod_hit;
                else
                    held_mods_next = held_mods_reg & ~mod_hit;
            end
            else
            begin
                emit        = 1'b1;
                kind_next   = KIND_KEY;
                kstate_next = s1_state_reg;
                kcode_next  = s1_code_reg;
            end
        end
        else if (s1_type_reg == EV_REL)
        begin
            if (s1_code_reg == AXIS_X)
            begin
                cur_x_next = cur_x_reg + s1_delta_reg;
                moved_next = 1'b1;
            end
            else if (s1_code_reg == AXIS_Y)
            begin
                cur_y_next = cur_y_reg + s1_delta_reg;
                moved_next = 1'b1;
            end
        end
        else if (s1_type_reg == EV_SYN)
        begin
            if (moved_reg)
            begin
                emit       = 1'b1;
                kind_next  = KIND_MOVE;
                px_next    = 32'($signed(cur_x_reg));
                py_next    = 32'($signed(cur_y_reg));
                moved_next = 1'b0;
            end
        end
        else
        begin
            // Unknown event types change nothing.
            emit = 1'b0;
        end
    end

    // Architectural state. Configuration writes must arrive only while the block is
    // idle; the block does not enforce this, and a write wins over a stage-two update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= ACCEL_RESET;
            held_mods_reg <= MOD_NONE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            moved_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL:   accel_reg <= cfg_data[7:0];
                CFG_START_X: cur_x_reg <= cfg_data[COORD_BITS-1:0];
                CFG_START_Y: cur_y_reg <= cfg_data[COORD_BITS-1:0];
                default:     ;
            endcase
        end
        else if (s1_adv)
        begin
            held_mods_reg <= held_mods_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            moved_reg     <= moved_next;
        end
    end

    // Report register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (reports.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            kind_reg   <= kind_next;
            kstate_reg <= kstate_next;
            mods_reg   <= held_mods_reg;
            kcode_reg  <= kcode_next;
            btn_reg    <= btn_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
        end
    end

    assign reports.valid         = out_valid_reg;
    assign reports.report_kind   = kind_reg;
    assign reports.key_state     = kstate_reg;
    assign reports.modifier_bits = mods_reg;
    assign reports.key_code      = kcode_reg;
    assign reports.button_id     = btn_reg;
    assign reports.pos_x         = px_reg;
    assign reports.pos_y         = py_reg;

    // The input side only stalls behind a full stage one and a blocked report.
    `IED_ASSERT(a_in_stall_cause,
        !events.ready |-> (s1_valid_reg && out_valid_reg && !reports.ready),
        "input stalled without a blocked report")
    // A modifier key event must never reach the report channel.
    `IED_ASSERT_NEVER(a_mod_no_report,
        s1_adv && (s1_type_reg == EV_KEY) && !is_btn && (mod_hit != MOD_NONE) && emit,
        "modifier key event produced a report")
    // A report leaving stage two always clears the moved flag unless it is a key report.
    `IED_ASSERT(a_moved_cleared,
        (s1_adv && emit && (kind_next != KIND_KEY)) |=> !moved_reg,
        "moved flag still set after a button or move report")
    // Key reports carry no button or position.
    `IED_ASSERT(a_key_fields_zero,
        (reports.valid && (reports.report_kind == KIND_KEY))
            |-> (reports.button_id == 3'd0 && reports.pos_x == 32'd0
                 && reports.pos_y == 32'd0),
        "key report with a button or position")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the input event decoder: directed and random event streams,
// with a built-in decoder predictor, random stalls on both channels and register phases.
// Depends on ied_pkg, ied_event_if, ied_report_if and the input_event_decoder RTL.

module tb_top;
    import ied_pkg::*;

    // Index 3 selects no register; a write to it must leave every register alone.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Pointer coordinate width of the block as instantiated below.
    localparam int COORD_W = COORD_BITS_DEF;

    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the one long receiver hold-off that fills the block up.
    localparam int LONG_HOLD = 400;
    // Quiet cycles after the last report, covering events still in flight that make no report.
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int HOLD_PHASE = 3;

    // Receiver stall patterns.
    localparam int STALL_NONE = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct packed {
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
    } event_rec_t;

    typedef struct packed {
        logic [1:0]  kind;
        key_state_t  state;
        mod_mask_t   mods;
        logic [15:0] code;
        logic [2:0]  button;
        logic [31:0] x;
        logic [31:0] y;
    } report_rec_t;

    // Clock and reset. Reset starts asserted so that every driver below comes up in a
    // known state before the first edge.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side copies of every block input. They carry initial values, so the
    // block never sees an unknown input, not even before the first clock edge.
    logic        drv_valid = 1'b0;
    logic [15:0] drv_type = '0;
    logic [15:0] drv_code = '0;
    logic [31:0] drv_value = '0;
    logic        rcv_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ied_event_if events_ch ();
    ied_report_if reports_ch ();

    assign events_ch.valid = drv_valid;
    assign events_ch.ev_type = drv_type;
    assign events_ch.ev_code = drv_code;
    assign events_ch.ev_value = drv_value;
    assign reports_ch.ready = rcv_ready;

    input_event_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events_ch),
        .reports   (reports_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: the decoder's modifiers, pointer and moved flag, plus its
    // acceleration register. Config writes and accepted events both update it.
    logic [7:0]  model_accel = ACCEL_RESET;
    mod_mask_t   model_mods = MOD_NONE;
    logic [31:0] model_x = '0;
    logic [31:0] model_y = '0;
    logic        model_moved = 1'b0;

    // Events waiting to be offered, and reports still owed by the block, oldest first.
    event_rec_t  pending_events[$];
    report_rec_t expected_reports[$];
    event_rec_t  offered;

    // Sender burst shaping and receiver hold-off bookkeeping.
    int burst_left = 0;
    int gap_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_mode = STALL_NONE;
    int mode_left = 0;
    int stall_phase = 0;

    // Run statistics.
    int accepted_events = 0;
    int checked_reports = 0;
    int report_count[3] = '{0, 0, 0};
    int cfg_writes = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A key value saturates: negative reads as released, anything above two as repeat.
    function automatic key_state_t clamp_key_value(input logic [31:0] raw);
        if (raw[31])
            return KS_RELEASED;
        if (raw > 32'd2)
            return KS_REPEAT;
        return raw[1:0];
    endfunction

    function automatic mod_mask_t modifier_of(input logic [15:0] code);
        case (code)
            CODE_CTRL_L, CODE_CTRL_R:   return MOD_CTRL;
            CODE_SHIFT_L, CODE_SHIFT_R: return MOD_SHIFT;
            CODE_ALT_L, CODE_ALT_R:     return MOD_ALT;
            default:                    return MOD_NONE;
        endcase
    endfunction

    // Positions live in COORD_W bits and are seen sign extended to 32 bits.
    function automatic logic [31:0] fold_coord(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        for (int b = COORD_W; b < 32; b++)
            r[b] = v[COORD_W - 1];
        return r;
    endfunction

    // Applies one accepted event to the predictor state. Returns 1 and fills rep when
    // the event should produce a report. Unused report fields stay zero.
    function automatic bit decode_event(input event_rec_t ev, output report_rec_t rep);
        key_state_t  st;
        mod_mask_t   m;
        logic [31:0] step;
        logic [15:0] offs;
        rep = '0;
        rep.mods = model_mods;
        st = clamp_key_value(ev.ev_value);
        m = modifier_of(ev.ev_code);
        if (ev.ev_type == EV_KEY)
        begin
            if (ev.ev_code >= BTN_FIRST && ev.ev_code <= BTN_LAST)
            begin
                // A click reports where the pointer is and consumes any pending motion.
                offs = ev.ev_code - BTN_FIRST;
                rep.kind = KIND_BUTTON;
                rep.state = st;
                rep.code = ev.ev_code;
                rep.button = offs[2:0];
                rep.x = model_x;
                rep.y = model_y;
                model_moved = 1'b0;
                return 1'b1;
            end
            if (m != MOD_NONE)
            begin
                if (st == KS_RELEASED)
                    model_mods = model_mods & ~m;
                else
                    model_mods = model_mods | m;
                return 1'b0;
            end
            rep.kind = KIND_KEY;
            rep.state = st;
            rep.code = ev.ev_code;
            return 1'b1;
        end
        if (ev.ev_type == EV_REL)
        begin
            // The product keeps only its low 32 bits before it is added.
            step = ev.ev_value * {24'd0, model_accel};
            if (ev.ev_code == AXIS_X)
            begin
                model_x = fold_coord(model_x + step);
                model_moved = 1'b1;
            end
            else if (ev.ev_code == AXIS_Y)
            begin
                model_y = fold_coord(model_y + step);
                model_moved = 1'b1;
            end
            return 1'b0;
        end
        if (ev.ev_type == EV_SYN && model_moved)
        begin
            rep.kind = KIND_MOVE;
            rep.x = model_x;
            rep.y = model_y;
            model_moved = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queues one event. Events the block drops outright (unknown type, or a relative
    // event on an axis other than X or Y) do not count toward the stimulus size.
    task automatic push_event(input logic [15:0] t, input logic [15:0] c,
                              input logic [31:0] v, inout int useful);
        event_rec_t ev;
        ev.ev_type = t;
        ev.ev_code = c;
        ev.ev_value = v;
        pending_events.insert(pending_events.size(), ev);
        if ((t == EV_SYN || t == EV_KEY || t == EV_REL) &&
            !(t == EV_REL && c != AXIS_X && c != AXIS_Y))
            useful++;
    endtask

    // Mostly small motion in both directions, now and then any 32-bit amount.
    function automatic logic [31:0] motion_amount();
        int s;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        s = $urandom_range(0, 40) - 20;
        return s;
    endfunction

    // Mostly a legal key state, now and then any 32-bit value to hit saturation.
    function automatic logic [31:0] key_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [15:0] modifier_code();
        case ($urandom_range(0, 5))
            0:       return CODE_CTRL_L;
            1:       return CODE_CTRL_R;
            2:       return CODE_SHIFT_L;
            3:       return CODE_SHIFT_R;
            4:       return CODE_ALT_L;
            default: return CODE_ALT_R;
        endcase
    endfunction

    // Random stream. Most of it is shaped like real device traffic (motion packets closed
    // by a sync, key strokes wrapped in modifiers, clicks), the rest is noise and broken
    // sequences: stray syncs, bad axes, codes just outside the button range.
    task automatic queue_random(input int target);
        int          useful;
        int          pick;
        logic [15:0] code;
        logic [15:0] mkey;
        useful = 0;
        while (useful < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                repeat ($urandom_range(1, 4))
                    push_event(EV_REL, ($urandom_range(0, 1) != 0) ? AXIS_Y : AXIS_X,
                               motion_amount(), useful);
                if ($urandom_range(0, 7) != 0)
                    push_event(EV_SYN, 16'd0, 32'd0, useful);
            end
            else if (pick < 60)
            begin
                mkey = modifier_code();
                if ($urandom_range(0, 1) != 0)
                    push_event(EV_KEY, mkey, key_value(), useful);
                code = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 120));
                push_event(EV_KEY, code, 32'd1, useful);
                push_event(EV_KEY, code, key_value(), useful);
                if ($urandom_range(0, 1) != 0)
                    push_event(EV_KEY, mkey, 32'd0, useful);
            end
            else if (pick < 75)
            begin
                code = BTN_FIRST + 16'($urandom_range(0, 4));
                if ($urandom_range(0, 1) != 0)
                    push_event(EV_REL, AXIS_X, motion_amount(), useful);
                push_event(EV_KEY, code, key_value(), useful);
                push_event(EV_KEY, code, 32'd0, useful);
                push_event(EV_SYN, 16'd0, 32'd0, useful);
            end
            else if (pick < 90)
            begin
                push_event(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                           16'($urandom), $urandom, useful);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: push_event(EV_SYN, 16'($urandom), $urandom, useful);
                    1: push_event(EV_REL, 16'($urandom_range(2, 65535)), $urandom, useful);
                    2: push_event(EV_KEY, ($urandom_range(0, 1) != 0) ? BTN_FIRST - 16'd1
                                                                   : BTN_LAST + 16'd1,
                                  key_value(), useful);
                    default: push_event(EV_KEY, modifier_code(), $urandom, useful);
                endcase
            end
        end
    endtask

    // Presents one register write; it takes effect at the next rising edge. The
    // predictor follows at once, which is safe because the block is idle here.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_writes++;
        case (idx)
            CFG_ACCEL:   model_accel = data[7:0];
            CFG_START_X: model_x = fold_coord(data);
            CFG_START_Y: model_y = fold_coord(data);
            default:     ;
        endcase
    endtask

    // Waits until every queued event has been taken and every owed report has come
    // back, then lets the pipeline empty of events that produce no report. The check
    // runs on the falling edge, after the driver's rising-edge updates have settled.
    task automatic settle();
        while (pending_events.size() != 0 || drv_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic note_failure(input string what, input report_rec_t want,
                                input report_rec_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("error: %s: expected kind=%0d state=%0d mods=%0d code=%h btn=%0d x=%h y=%h,",
                     what, want.kind, want.state, want.mods, want.code, want.button,
                     want.x, want.y,
                     " got kind=%0d state=%0d mods=%0d code=%h btn=%0d x=%h y=%h",
                     got.kind, got.state, got.mods, got.code, got.button, got.x, got.y);
    endtask

    // Event driver. A new event is put up only when the channel is free, which is when
    // nothing is offered or the offered transaction is being taken at this edge. Each
    // accepted event goes through the predictor right here, so expectations are queued
    // in acceptance order. The sender works in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : event_driver
        report_rec_t rep;
        logic        nxt_valid;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_type <= '0;
            drv_code <= '0;
            drv_value <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!drv_valid || events_ch.ready)
        begin
            if (drv_valid)
            begin
                accepted_events++;
                if (decode_event(offered, rep))
                    expected_reports.insert(expected_reports.size(), rep);
            end
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_events.size() > 0)
            begin
                offered = pending_events.pop_front();
                drv_type <= offered.ev_type;
                drv_code <= offered.ev_code;
                drv_value <= offered.ev_value;
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // About a quarter of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            drv_valid <= nxt_valid;
        end
    end

    // Report monitor. Every report transaction is compared field by field with the
    // oldest owed report; a report with nothing owed is a failure on its own.
    always @(posedge clk)
    begin : report_monitor
        report_rec_t got;
        report_rec_t want;
        if (rst_n && reports_ch.valid && rcv_ready)
        begin
            got.kind = reports_ch.report_kind;
            got.state = reports_ch.key_state;
            got.mods = reports_ch.modifier_bits;
            got.code = reports_ch.key_code;
            got.button = reports_ch.button_id;
            got.x = reports_ch.pos_x;
            got.y = reports_ch.pos_y;
            if (expected_reports.size() == 0)
            begin
                note_failure("report with none owed", '0, got);
            end
            else
            begin
                want = expected_reports.pop_front();
                checked_reports++;
                report_count[want.kind]++;
                if (got.kind !== want.kind || got.state !== want.state ||
                    got.mods !== want.mods || got.code !== want.code ||
                    got.button !== want.button || got.x !== want.x || got.y !== want.y)
                    note_failure("report mismatch", want, got);
            end
        end
    end

    // Receiver stall pattern. The pattern is redrawn whenever its mode count runs out,
    // between always ready, light and heavy random stalls, and a fixed one-in-five stall.
    // A stimulus hold-off request overrides all of that until the count kept here runs out.
    always @(posedge clk or negedge rst_n)
    begin : report_stall
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
            stall_mode = STALL_NONE;
            mode_left = 0;
            hold_left = 0;
            hold_served = 0;
            stall_phase = 0;
        end
        else
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            stall_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rcv_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:  rcv_ready <= 1'b1;
                    STALL_LIGHT: rcv_ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY: rcv_ready <= ($urandom_range(0, 2) == 0);
                    default:     rcv_ready <= ((stall_phase % 5) != 0);
                endcase
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count. Reaching the
    // limit means the block has hung, so the run stops as failed.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (drv_valid && events_ch.ready) || (reports_ch.valid && rcv_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("error: no transaction for %0d cycles, %0d reports still owed",
                     WATCHDOG_LIMIT, expected_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: reset, a directed pass under the reset register values, then random
    // phases, each under its own register setting, written while the block is idle.
    initial
    begin : stimulus
        int directed_useful;
        directed_useful = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // A plain key, then every modifier pressed, repeated and released, including
        // saturated values and releasing a bit with the other key of the same pair.
        push_event(EV_KEY, 16'd30, 32'd1, directed_useful);
        push_event(EV_KEY, CODE_CTRL_L, 32'd1, directed_useful);
        push_event(EV_KEY, CODE_SHIFT_L, 32'd2, directed_useful);
        push_event(EV_KEY, CODE_ALT_R, 32'h7FFF_FFFF, directed_useful);
        push_event(EV_KEY, 16'hFFFF, 32'hFFFF_FFFF, directed_useful);
        push_event(EV_KEY, 16'd0, 32'd3, directed_useful);
        push_event(EV_KEY, CODE_CTRL_R, 32'h8000_0000, directed_useful);
        push_event(EV_KEY, CODE_SHIFT_R, 32'd0, directed_useful);
        push_event(EV_KEY, CODE_ALT_L, 32'd0, directed_useful);
        // Motion under the reset acceleration, a move report, then a sync with no motion.
        push_event(EV_REL, AXIS_X, 32'd1, directed_useful);
        push_event(EV_REL, AXIS_Y, 32'hFFFF_FFFF, directed_useful);
        push_event(EV_SYN, 16'd0, 32'd0, directed_useful);
        push_event(EV_SYN, 16'd0, 32'd0, directed_useful);
        // Product wrap, then relative events on axes that do not exist.
        push_event(EV_REL, AXIS_X, 32'h7FFF_FFFF, directed_useful);
        push_event(EV_REL, 16'd2, 32'd5, directed_useful);
        push_event(EV_REL, 16'hFFFF, 32'h8000_0000, directed_useful);
        // A click consumes the pending motion, so the following sync reports nothing.
        push_event(EV_KEY, BTN_FIRST, 32'd1, directed_useful);
        push_event(EV_SYN, 16'd0, 32'd0, directed_useful);
        push_event(EV_KEY, BTN_LAST, 32'd0, directed_useful);
        push_event(EV_KEY, BTN_FIRST + 16'd2, 32'd5, directed_useful);
        // Codes just outside the button range are plain keys.
        push_event(EV_KEY, BTN_FIRST - 16'd1, 32'd1, directed_useful);
        push_event(EV_KEY, BTN_LAST + 16'd1, 32'd1, directed_useful);
        // Unknown event types are dropped without touching any state.
        push_event(16'd3, 16'd0, 32'd1, directed_useful);
        push_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, directed_useful);
        // Y wrap, then a sync whose code and value carry junk.
        push_event(EV_REL, AXIS_Y, 32'h8000_0000, directed_useful);
        push_event(EV_SYN, 16'hFFFF, 32'h1234_5678, directed_useful);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // The first phases take the extremes: no acceleration with the pointer
            // at the edges, full acceleration with the edges swapped, unit steps
            // from the origin. Later phases pick settings at random.
            case (p)
                0:
                begin
                    write_reg(CFG_ACCEL, 32'd0);
                    write_reg(CFG_START_X, 32'h7FFF_FFFF);
                    write_reg(CFG_START_Y, 32'h8000_0000);
                end
                1:
                begin
                    write_reg(CFG_ACCEL, 32'd255);
                    write_reg(CFG_START_X, 32'h8000_0000);
                    write_reg(CFG_START_Y, 32'h7FFF_FFFF);
                    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(CFG_ACCEL, 32'd1);
                    write_reg(CFG_START_X, 32'd0);
                    write_reg(CFG_START_Y, 32'd0);
                end
                default:
                begin
                    // Upper data bits are random too; only the low byte belongs to accel.
                    write_reg(CFG_ACCEL, $urandom);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        write_reg(CFG_START_X, $urandom_range(0, 2000) - 1000);
                        write_reg(CFG_START_Y, $urandom_range(0, 2000) - 1000);
                    end
                    else
                    begin
                        write_reg(CFG_START_X, $urandom);
                        write_reg(CFG_START_Y, $urandom);
                    end
                    if ($urandom_range(0, 1) != 0)
                        write_reg(CFG_UNUSED, $urandom);
                end
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;

            // One phase starts with the receiver held off while the sender keeps going,
            // so the block backs up and has to stall its event input.
            if (p == HOLD_PHASE)
                hold_requests++;
            queue_random(ITEMS_PER_PHASE);
            settle();
        end

        $display("ran %0d events: %0d reports checked (%0d key, %0d button, %0d move)",
                 accepted_events, checked_reports, report_count[KIND_KEY],
                 report_count[KIND_BUTTON], report_count[KIND_MOVE]);
        $display("directed pass plus %0d random phases, %0d register writes, one long stall",
                 RANDOM_PHASES, cfg_writes);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
